### sv/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
// Used by the channel interfaces and by the top level; no dependencies.
package modexp_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = $clog2(DataW);
  localparam int unsigned UnitW = DataW + 2;
  localparam int unsigned StatW = 2;

  typedef logic [DataW-1:0] data_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [UnitW-1:0] unit_t;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_MOD_ZERO = 2'd1,
    ST_MOD_LOW  = 2'd2
  } status_e;

  typedef enum logic {
    CMD_POWER   = 1'b0,
    CMD_INVERSE = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_REDUCE,
    FSM_CHECK,
    FSM_MUL,
    FSM_SQR,
    FSM_FINISH
  } fsm_e;

endpackage

### sv/modexp_in_if.sv
// Input channel: command, base and exponent with valid/ready.
// Depends on modexp_pkg.
interface modexp_in_if;
  import modexp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [DataW-1:0]     base_value;
  logic [DataW-1:0]     exponent_value;

  modport source (output valid, command, base_value, exponent_value, input ready);
  modport sink   (input valid, command, base_value, exponent_value, output ready);
endinterface

### sv/modexp_out_if.sv
// Output channel: result and status with valid/ready.
// Depends on modexp_pkg.
interface modexp_out_if;
  import modexp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [DataW-1:0]     result_value;
  logic [StatW-1:0]     status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

### sv/modular_exponentiation.sv
// After a word is accepted the base is first reduced by the modulus; then, for each exponent
// bit up to the highest set one, a multiply into the accumulator when the bit is set and a
// square follow; the shared double-add-reduce unit takes one bit a cycle.
// Error words skip the arithmetic and go straight to the output.
// One word at a time: in_i.ready is high only while the sequencer is idle, so a new word
// is taken only once the last one is in the output register; an output stall delays that.
// Reset (rst_ni low, async) clears the sequencer and output valid, modulus goes to 1.
module modular_exponentiation (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [modexp_pkg::DataW-1:0] cfg_wdata_i,
  modexp_in_if.sink                    in_i,
  modexp_out_if.source                 out_o
);
  import modexp_pkg::*;

  fsm_e    state_q, state_d;
  cnt_t    cnt_q, cnt_d;
  data_t   mod_q;
  data_t   m_q, m_d;
  data_t   work_q, work_d;
  data_t   acc_q, acc_d;
  data_t   sq_q, sq_d;
  data_t   e_q, e_d;
  data_t   base_q, base_d;
  status_e stat_q, stat_d;
  logic    out_valid_q, out_valid_d;
  data_t   out_res_q, out_res_d;
  status_e out_stat_q, out_stat_d;

  // shared unit: (2*work + addend) mod m, with work and addend below m
  data_t unit_b;
  unit_t unit_t_sum, unit_d1, unit_d2, unit_m1, unit_m2;
  data_t unit_res;

  assign unit_t_sum = {1'b0, work_q, 1'b0} + {2'b00, unit_b};
  assign unit_m1    = {2'b00, m_q};
  assign unit_m2    = {1'b0, m_q, 1'b0};
  assign unit_d1    = unit_t_sum - unit_m1;
  assign unit_d2    = unit_t_sum - unit_m2;
  assign unit_res   = (unit_t_sum >= unit_m2) ? unit_d2[DataW-1:0] :
                      (unit_t_sum >= unit_m1) ? unit_d1[DataW-1:0] :
                      unit_t_sum[DataW-1:0];

  assign in_i.ready         = (state_q == FSM_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.status       = out_stat_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    m_d         = m_q;
    work_d      = work_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    e_d         = e_q;
    base_d      = base_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_res_d   = out_res_q;
    out_stat_d  = out_stat_q;
    unit_b      = '0;

    case (state_q)
      FSM_IDLE: begin
        if (in_i.valid) begin
          m_d    = mod_q;
          base_d = in_i.base_value;
          acc_d  = data_t'(1);
          work_d = '0;
          cnt_d  = cnt_t'(DataW - 1);
          stat_d = ST_OK;
          e_d    = (in_i.command == CMD_INVERSE) ? (mod_q - data_t'(2))
                                                 : in_i.exponent_value;
          if (mod_q == '0) begin
            acc_d   = '0;
            stat_d  = ST_MOD_ZERO;
            state_d = FSM_FINISH;
          end else if (in_i.command == CMD_INVERSE && mod_q < data_t'(2)) begin
            acc_d   = '0;
            stat_d  = ST_MOD_LOW;
            state_d = FSM_FINISH;
          end else begin
            state_d = FSM_REDUCE;
          end
        end
      end
      FSM_REDUCE: begin
        // shift base in MSB first: remainder by restoring division
        unit_b = {{(DataW-1){1'b0}}, base_q[cnt_q]};
        work_d = unit_res;
        cnt_d  = cnt_q - cnt_t'(1);
        if (cnt_q == '0) begin
          sq_d    = unit_res;
          state_d = FSM_CHECK;
        end
      end
      FSM_CHECK: begin
        work_d = '0;
        cnt_d  = cnt_t'(DataW - 1);
        if (e_q == '0) begin
          state_d = FSM_FINISH;
        end else if (e_q[0]) begin
          state_d = FSM_MUL;
        end else begin
          state_d = FSM_SQR;
        end
      end
      FSM_MUL: begin
        unit_b = sq_q[cnt_q] ? acc_q : '0;
        work_d = unit_res;
        cnt_d  = cnt_q - cnt_t'(1);
        if (cnt_q == '0) begin
          acc_d   = unit_res;
          work_d  = '0;
          cnt_d   = cnt_t'(DataW - 1);
          state_d = FSM_SQR;
        end
      end
      FSM_SQR: begin
        unit_b = sq_q[cnt_q] ? sq_q : '0;
        work_d = unit_res;
        cnt_d  = cnt_q - cnt_t'(1);
        if (cnt_q == '0) begin
          sq_d    = unit_res;
          e_d     = e_q >> 1;
          state_d = FSM_CHECK;
        end
      end
      FSM_FINISH: begin
        // hold until the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = acc_q;
          out_stat_d  = stat_q;
          state_d     = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      out_valid_q <= 1'b0;
      mod_q       <= data_t'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    m_q        <= m_d;
    work_q     <= work_d;
    acc_q      <= acc_d;
    sq_q       <= sq_d;
    e_q        <= e_d;
    base_q     <= base_d;
    stat_q     <= stat_d;
    out_res_q  <= out_res_d;
    out_stat_q <= out_stat_d;
  end

  // running square is reduced, accumulator is reduced or still the initial one
  a_check_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_CHECK |-> (sq_q < m_q) && ((acc_q < m_q) || (acc_q == data_t'(1))))
    else $error("operands not reduced at bit check");

  a_work_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_REDUCE || state_q == FSM_MUL || state_q == FSM_SQR) |-> work_q < m_q)
    else $error("shared unit operand not below modulus");

  a_exp_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_SQR && cnt_q == '0) |=> (state_q == FSM_CHECK) && (e_q == ($past(e_q) >> 1)))
    else $error("exponent not advanced after square");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stat_q != ST_OK) |-> out_res_q == '0)
    else $error("error word carries nonzero result");

endmodule
